// ===== src/utvl_pkg.sv =====
// Package for the UTF-8 / ASCII text validator.
// Holds the payload structs, the mode and error codes and the tracker state type.
// No dependencies.
`default_nettype none

package utvl_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT_UTF8   = 2'd0,
    MODE_TEXT_ASCII  = 2'd1,
    MODE_PLAIN_UTF8  = 2'd2,
    MODE_PLAIN_ASCII = 2'd3
  } check_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_NUL       = 2'd2,
    ERR_RANGE     = 2'd3
  } error_kind_t;

  localparam int unsigned OUT_COUNT_WIDTH = 16;

  localparam logic [7:0] BYTE_NUL       = 8'h00;
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_PRINT_LO  = 8'h20;
  localparam logic [7:0] BYTE_PRINT_HI  = 8'h7E;
  localparam logic [7:0] LEAD_E0        = 8'he0;
  localparam logic [7:0] LEAD_ED        = 8'hed;
  localparam logic [7:0] LEAD_EF        = 8'hef;
  localparam logic [7:0] LEAD_F0        = 8'hf0;
  localparam logic [7:0] LEAD_F4        = 8'hf4;
  localparam logic [7:0] CONT_8F        = 8'h8f;
  localparam logic [7:0] CONT_BF        = 8'hbf;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        last_out;
    logic        verdict_ok;
    error_kind_t error_kind;
    logic [OUT_COUNT_WIDTH-1:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  conts_remaining;
    logic [7:0]  lead_value;
    logic [1:0]  cont_position;
    logic        noncharacter_pending;
    logic        utf8_failed;
    error_kind_t first_fault;
  } track_state_t;

endpackage

`default_nettype wire

// ===== src/utvl_check.sv =====
// Combinational per-byte check: UTF-8 sequence tracking, per-byte faults and verdict.
// Depends on utvl_pkg.
`default_nettype none

module utvl_check (
  input  utvl_pkg::track_state_t state,
  input  utvl_pkg::check_mode_t  mode,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output utvl_pkg::track_state_t state_next,
  output utvl_pkg::error_kind_t  error_kind
);

  utvl_pkg::track_state_t fed;
  utvl_pkg::error_kind_t  fault;
  logic                   outside_print;

  // UTF-8 sequence tracker.
  always_comb begin
    fed = state;
    if (!state.utf8_failed) begin
      if (state.conts_remaining == 2'd0) begin
        fed.noncharacter_pending = 1'b0;
        if (data_byte[7]) begin
          if ((data_byte & 8'he0) == 8'hc0) begin
            // C0 and C1 can only start overlong two-byte forms.
            if ((data_byte & 8'hfe) == 8'hc0) begin
              fed.utf8_failed = 1'b1;
            end else begin
              fed.conts_remaining = 2'd1;
            end
          end else if ((data_byte & 8'hf0) == 8'he0) begin
            fed.conts_remaining = 2'd2;
          end else if ((data_byte & 8'hf8) == 8'hf0) begin
            if (data_byte > utvl_pkg::LEAD_F4) begin
              fed.utf8_failed = 1'b1;
            end else begin
              fed.conts_remaining = 2'd3;
            end
          end else begin
            fed.utf8_failed = 1'b1;
          end
          if (!fed.utf8_failed) begin
            fed.lead_value    = data_byte;
            fed.cont_position = 2'd1;
          end
        end
      end else if (data_byte[7:6] != 2'b10) begin
        fed.utf8_failed = 1'b1;
      end else begin
        if (state.cont_position == 2'd1) begin
          if ((state.lead_value == utvl_pkg::LEAD_E0 && data_byte[7:5] == 3'b100) ||
              (state.lead_value == utvl_pkg::LEAD_ED && data_byte[7:5] == 3'b101) ||
              (state.lead_value == utvl_pkg::LEAD_F0 && data_byte[7:4] == 4'b1000) ||
              (state.lead_value == utvl_pkg::LEAD_F4 && data_byte > utvl_pkg::CONT_8F)) begin
            fed.utf8_failed = 1'b1;
          end else begin
            fed.noncharacter_pending = (state.lead_value == utvl_pkg::LEAD_EF) &&
                                       (data_byte == utvl_pkg::CONT_BF);
          end
        end else if (state.cont_position == 2'd2) begin
          // EF BF BE and EF BF BF are the noncharacters U+FFFE and U+FFFF.
          if (state.noncharacter_pending && data_byte[7:1] == 7'b1011111) begin
            fed.utf8_failed = 1'b1;
          end else begin
            fed.noncharacter_pending = 1'b0;
          end
        end
        if (!fed.utf8_failed) begin
          fed.cont_position   = state.cont_position + 2'd1;
          fed.conts_remaining = state.conts_remaining - 2'd1;
        end
      end
    end
  end

  // Per-byte fault under the current mode.
  assign outside_print = (data_byte < utvl_pkg::BYTE_PRINT_LO) ||
                         (data_byte > utvl_pkg::BYTE_PRINT_HI);

  always_comb begin
    fault = utvl_pkg::ERR_NONE;
    case (mode)
      utvl_pkg::MODE_TEXT_UTF8: begin
        if (data_byte == utvl_pkg::BYTE_NUL) fault = utvl_pkg::ERR_NUL;
      end
      utvl_pkg::MODE_TEXT_ASCII: begin
        if (data_byte == utvl_pkg::BYTE_NUL) fault = utvl_pkg::ERR_NUL;
        else if (outside_print) fault = utvl_pkg::ERR_RANGE;
      end
      utvl_pkg::MODE_PLAIN_ASCII: begin
        if (outside_print && data_byte != utvl_pkg::BYTE_LF) fault = utvl_pkg::ERR_RANGE;
      end
      default: begin
        fault = utvl_pkg::ERR_NONE;
      end
    endcase
  end

  always_comb begin
    utvl_pkg::track_state_t upd;
    upd = fed;
    if (upd.first_fault == utvl_pkg::ERR_NONE) begin
      upd.first_fault = fault;
    end
    error_kind = utvl_pkg::ERR_NONE;
    state_next = upd;
    if (last_byte) begin
      // A sequence still open at the end of the buffer is truncated.
      if (upd.conts_remaining != 2'd0) begin
        upd.utf8_failed = 1'b1;
      end
      if ((mode == utvl_pkg::MODE_TEXT_UTF8 || mode == utvl_pkg::MODE_PLAIN_UTF8) &&
          upd.utf8_failed) begin
        error_kind = utvl_pkg::ERR_MALFORMED;
      end else begin
        error_kind = upd.first_fault;
      end
      state_next = '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/utf8_ascii_text_validator_unit.sv =====
// Top level of the UTF-8 / ASCII text validator: mode register, tracker state,
// saturating byte counter and result register. Depends on utvl_pkg and utvl_check.
`default_nettype none

// Each byte is checked in the cycle it is accepted and its result is held in the
// output register in the next cycle; one byte is taken every clock cycle, and the only
// stall comes from out_ready being low while a result is waiting.
// The verdict (verdict_ok, error_kind) is valid on the result that carries last_out,
// and all per-buffer state clears after that byte. A write to check_mode takes
// effect from the next byte; mode writes are expected only while the block is idle.
module utf8_ascii_text_validator_unit #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                check_mode_we,
  input  logic [1:0]          check_mode_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  utvl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output utvl_pkg::out_item_t out_data
);

  localparam int unsigned OW = utvl_pkg::OUT_COUNT_WIDTH;

  utvl_pkg::check_mode_t  check_mode;
  utvl_pkg::track_state_t state;
  utvl_pkg::track_state_t state_next;
  utvl_pkg::error_kind_t  error_kind;
  logic [COUNT_WIDTH-1:0] seen_count;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [OW-1:0]          count_shown;
  logic                   in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  utvl_check u_check (
    .state      (state),
    .mode       (check_mode),
    .data_byte  (in_data.data_byte),
    .last_byte  (in_data.last_byte),
    .state_next (state_next),
    .error_kind (error_kind)
  );

  assign count_inc = (&seen_count) ? seen_count : seen_count + COUNT_WIDTH'(1);

  generate
    if (COUNT_WIDTH > OW) begin : g_clip
      assign count_shown = (|count_inc[COUNT_WIDTH-1:OW]) ? {OW{1'b1}} : count_inc[OW-1:0];
    end else begin : g_extend
      assign count_shown = OW'(count_inc);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= utvl_pkg::MODE_TEXT_UTF8;
      state      <= '0;
      seen_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (check_mode_we) begin
        check_mode <= utvl_pkg::check_mode_t'(check_mode_wdata);
      end
      if (in_xfer) begin
        state      <= state_next;
        seen_count <= in_data.last_byte ? '0 : count_inc;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data.byte_out   <= in_data.data_byte;
      out_data.last_out   <= in_data.last_byte;
      out_data.verdict_ok <= in_data.last_byte && (error_kind == utvl_pkg::ERR_NONE);
      out_data.error_kind <= error_kind;
      out_data.byte_count <= count_shown;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_validator_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class for the UTF-8 / ASCII text validator testbench: predicts one
// result per accepted byte and checks the results in order. Depends on utvl_pkg.
package tb_validator_pkg;
  import utvl_pkg::*;

  class utf8_verdict_board;
    check_mode_t     mode;
    logic [1:0]      conts_left;
    logic [7:0]      lead_byte;
    logic [1:0]      cont_index;
    bit              nonchar_armed;
    bit              utf8_bad;
    error_kind_t     first_fault;
    longint unsigned bytes_seen;
    longint unsigned count_max;
    longint unsigned longest_buffer;
    out_item_t       awaited_results[$];
    int unsigned     mismatches;
    int unsigned     results_checked;
    int unsigned     buffers_closed;

    function new(int unsigned count_width);
      count_max = (64'd1 << count_width) - 1;
      mode = MODE_TEXT_UTF8;
      mismatches = 0;
      results_checked = 0;
      buffers_closed = 0;
      longest_buffer = 0;
      clear_buffer();
    endfunction

    function void clear_buffer();
      conts_left = '0;
      lead_byte = '0;
      cont_index = '0;
      nonchar_armed = 1'b0;
      utf8_bad = 1'b0;
      first_fault = ERR_NONE;
      bytes_seen = 0;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    // Advances the UTF-8 sequence tracker; a failure sticks until the buffer ends.
    function void track_utf8(logic [7:0] b);
      if (utf8_bad) return;
      if (conts_left == 0) begin
        nonchar_armed = 1'b0;
        if (b < 8'h80) return;
        if ((b & 8'he0) == 8'hc0) begin
          if ((b & 8'hfe) == 8'hc0) begin
            utf8_bad = 1'b1;
            return;
          end
          conts_left = 2'd1;
        end else if ((b & 8'hf0) == 8'he0) begin
          conts_left = 2'd2;
        end else if ((b & 8'hf8) == 8'hf0) begin
          if (b > LEAD_F4) begin
            utf8_bad = 1'b1;
            return;
          end
          conts_left = 2'd3;
        end else begin
          utf8_bad = 1'b1;
          return;
        end
        lead_byte = b;
        cont_index = 2'd1;
        return;
      end
      if ((b & 8'hc0) != 8'h80) begin
        utf8_bad = 1'b1;
        return;
      end
      if (cont_index == 2'd1) begin
        // Overlong three and four byte forms, surrogates and values past U+10FFFF.
        if ((lead_byte == LEAD_E0 && (b & 8'he0) == 8'h80) ||
            (lead_byte == LEAD_ED && (b & 8'he0) == 8'ha0) ||
            (lead_byte == LEAD_F0 && (b & 8'hf0) == 8'h80) ||
            (lead_byte == LEAD_F4 && b > CONT_8F)) begin
          utf8_bad = 1'b1;
          return;
        end
        nonchar_armed = (lead_byte == LEAD_EF && b == CONT_BF);
      end else if (cont_index == 2'd2) begin
        if (nonchar_armed && (b & 8'hfe) == 8'hbe) begin
          utf8_bad = 1'b1;
          return;
        end
        nonchar_armed = 1'b0;
      end
      cont_index = cont_index + 2'd1;
      conts_left = conts_left - 2'd1;
    endfunction

    function error_kind_t byte_fault(check_mode_t m, logic [7:0] b);
      case (m)
        MODE_TEXT_UTF8: begin
          if (b == BYTE_NUL) return ERR_NUL;
        end
        MODE_TEXT_ASCII: begin
          if (b == BYTE_NUL) return ERR_NUL;
          if (b < BYTE_PRINT_LO || b > BYTE_PRINT_HI) return ERR_RANGE;
        end
        MODE_PLAIN_ASCII: begin
          if ((b < BYTE_PRINT_LO && b != BYTE_LF) || b > BYTE_PRINT_HI) return ERR_RANGE;
        end
        default: ;
      endcase
      return ERR_NONE;
    endfunction

    function void take_byte(in_item_t it);
      out_item_t   want;
      error_kind_t fault;
      error_kind_t kind;
      if (bytes_seen < count_max) bytes_seen++;
      track_utf8(it.data_byte);
      fault = byte_fault(mode, it.data_byte);
      if (first_fault == ERR_NONE && fault != ERR_NONE) first_fault = fault;
      kind = ERR_NONE;
      if (it.last_byte) begin
        // A sequence cut off by the end of the buffer is malformed.
        if (conts_left != 0) utf8_bad = 1'b1;
        if ((mode == MODE_TEXT_UTF8 || mode == MODE_PLAIN_UTF8) && utf8_bad) begin
          kind = ERR_MALFORMED;
        end else begin
          kind = first_fault;
        end
      end
      want.byte_out = it.data_byte;
      want.last_out = it.last_byte;
      want.verdict_ok = it.last_byte && (kind == ERR_NONE);
      want.error_kind = kind;
      want.byte_count = (bytes_seen > 64'hFFFF) ? 16'hFFFF : bytes_seen[15:0];
      awaited_results.push_back(want);
      if (it.last_byte) begin
        if (bytes_seen > longest_buffer) longest_buffer = bytes_seen;
        buffers_closed++;
        clear_buffer();
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at result %0d: %s", results_checked, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with byte %02h arrived with nothing awaited", got.byte_out));
        return;
      end
      want = awaited_results.pop_front();
      if (got.byte_out !== want.byte_out)
        report($sformatf("byte_out %02h, want %02h", got.byte_out, want.byte_out));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %0b, want %0b", got.last_out, want.last_out));
      if (got.verdict_ok !== want.verdict_ok)
        report($sformatf("verdict_ok %0b, want %0b", got.verdict_ok, want.verdict_ok));
      if (got.error_kind !== want.error_kind)
        report($sformatf("error_kind %0d, want %0d", got.error_kind, want.error_kind));
      if (got.byte_count !== want.byte_count)
        report($sformatf("byte_count %0d, want %0d", got.byte_count, want.byte_count));
    endtask
  endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level testbench for utf8_ascii_text_validator_unit: drives byte buffers in all
// four check modes under three idle profiles. Depends on utvl_pkg and tb_validator_pkg.
module tb_top;
  import utvl_pkg::*;
  import tb_validator_pkg::*;

  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SEGMENT_ITEMS = 167;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       check_mode_we = 1'b0;
  logic [1:0] check_mode_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  int unsigned send_gap_pct = 6;
  int unsigned recv_stall_pct = 85;
  int unsigned cycle_count = 0;
  in_item_t    byte_backlog[$];
  check_mode_t mode_order[4] = '{MODE_TEXT_UTF8, MODE_TEXT_ASCII, MODE_PLAIN_UTF8,
                                 MODE_PLAIN_ASCII};
  utf8_verdict_board board;

  utf8_ascii_text_validator_unit #(
    .COUNT_WIDTH(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .check_mode_we(check_mode_we),
    .check_mode_wdata(check_mode_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Results are checked before the byte of the same edge is noted; since each result is
  // registered, the two can never belong to the same transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_result(out_data);
      if (in_valid && in_ready) board.take_byte(in_data);
    end
  end

  task automatic push_byte(logic [7:0] b, logic last = 1'b0);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    byte_backlog.push_back(it);
  endtask

  task automatic push_cont();
    push_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // Sequences that sit right on the edges of the UTF-8 rules, legal and illegal.
  task automatic push_edge_sequence();
    case ($urandom_range(0, 13))
      0:  begin push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBE); end
      1:  begin push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBF); end
      2:  begin push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBD); end
      3:  begin push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80); end
      4:  begin push_byte(8'hED); push_byte(8'h9F); push_byte(8'hBF); end
      5:  begin push_byte(8'hE0); push_byte(8'h9F); push_byte(8'hBF); end
      6:  begin push_byte(8'hE0); push_byte(8'hA0); push_byte(8'h80); end
      7:  begin push_byte(8'hF4); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80); end
      8:  begin push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF); end
      9:  begin push_byte(8'hF0); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF); end
      10: begin push_byte(8'hF0); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80); end
      11: begin push_byte(8'($urandom_range(8'hC0, 8'hC1))); push_cont(); end
      12: begin push_byte(8'($urandom_range(8'hF5, 8'hFF))); push_cont(); push_cont(); end
      default: push_cont();
    endcase
  endtask

  // Mostly well-formed characters with random content, plus cut-off sequences and noise.
  task automatic queue_random_buffer();
    int unsigned chars;
    int unsigned pick;
    logic [7:0]  lead;
    in_item_t    tail;
    chars = $urandom_range(1, 10);
    repeat (chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        push_byte(8'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI)));
      end else if (pick < 35) begin
        case ($urandom_range(0, 3))
          0: push_byte(BYTE_NUL);
          1: push_byte(BYTE_LF);
          2: push_byte(8'h7F);
          default: push_byte(8'($urandom_range(8'h00, 8'h1F)));
        endcase
      end else if (pick < 50) begin
        push_byte(8'($urandom_range(8'hC2, 8'hDF)));
        push_cont();
      end else if (pick < 65) begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        push_byte(lead);
        if (lead == LEAD_E0) push_byte(8'($urandom_range(8'hA0, 8'hBF)));
        else if (lead == LEAD_ED) push_byte(8'($urandom_range(8'h80, 8'h9F)));
        else push_cont();
        push_cont();
      end else if (pick < 77) begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        push_byte(lead);
        if (lead == LEAD_F0) push_byte(8'($urandom_range(8'h90, 8'hBF)));
        else if (lead == LEAD_F4) push_byte(8'($urandom_range(8'h80, 8'h8F)));
        else push_cont();
        push_cont();
        push_cont();
      end else if (pick < 85) begin
        push_edge_sequence();
      end else if (pick < 93) begin
        // A lead byte followed by too few continuation bytes.
        lead = 8'($urandom_range(8'hC2, 8'hF4));
        push_byte(lead);
        if (lead >= LEAD_F0) repeat ($urandom_range(0, 2)) push_cont();
        else if (lead >= LEAD_E0) repeat ($urandom_range(0, 1)) push_cont();
      end else begin
        push_byte(8'($urandom_range(8'h00, 8'hFF)));
      end
    end
    tail = byte_backlog.pop_back();
    tail.last_byte = 1'b1;
    byte_backlog.push_back(tail);
  endtask

  task automatic queue_directed();
    push_byte(BYTE_NUL, 1'b1);                                   // lone NUL
    push_byte(8'hFF, 1'b1);                                      // byte never legal in UTF-8
    push_byte(8'hC0); push_byte(8'h80, 1'b1);                    // overlong two-byte form
    push_byte(8'hE0); push_byte(8'h9F); push_byte(8'hBF, 1'b1);  // overlong three-byte form
    push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80, 1'b1);  // surrogate
    push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBE, 1'b1);  // U+FFFE
    push_byte(8'hF4); push_byte(8'h90); push_byte(8'h80);
    push_byte(8'h80, 1'b1);                                      // above U+10FFFF
    push_byte(8'hE2, 1'b1);                                      // truncated at the end
    push_byte(8'hF0); push_byte(8'h9F); push_byte(8'h98);
    push_byte(8'h80, 1'b1);                                      // legal four-byte form
    push_byte(8'h80); push_byte(BYTE_NUL, 1'b1);                 // malformed beats NUL
  endtask

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_backlog();
    while (byte_backlog.size() != 0) send_item(byte_backlog.pop_front());
    in_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) begin
      if (byte_backlog.size() == 0) queue_random_buffer();
      send_item(byte_backlog.pop_front());
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Mode writes happen only with no result outstanding; a buffer may still be open.
  task automatic write_mode(check_mode_t m);
    wait_drained();
    check_mode_we <= 1'b1;
    check_mode_wdata <= m;
    @(posedge clk);
    check_mode_we <= 1'b0;
    board.mode = m;
  endtask

  initial begin
    board = new(COUNT_BITS);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    send_backlog();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_gap_pct = 6;  recv_stall_pct = 85; end
        1: begin send_gap_pct = 85; recv_stall_pct = 6;  end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int m = 0; m < 4; m++) begin
        write_mode(mode_order[(p == 1) ? 3 - m : m]);
        run_random(SEGMENT_ITEMS);
      end
    end

    write_mode(MODE_TEXT_UTF8);
    run_random(20);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Covered %0d results in %0d buffers across all four check modes",
             board.results_checked, board.buffers_closed);
    $display("and three idle profiles; the longest buffer held %0d bytes.",
             board.longest_buffer);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
